>>> src/ads_pkg.sv
`timescale 1ns / 1ps

package ads_pkg;

	// Default build values.
	localparam int DEF_MAX_STEPS   = 8;
	localparam int DEF_SAMPLE_BITS = 24;

	// Coefficient format: signed Q2.14.
	localparam int COEFF_BITS = 16;
	localparam int FRAC_COEFF = 14;

	// Configuration port.
	localparam int STEP_BITS      = 4;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ADVECT,
		REG_DIFFUSE,
		REG_STEPS
	} cfg_reg_t;

	localparam logic signed [COEFF_BITS-1:0] ADVECT_RESET  = 16'sd4096;
	localparam logic signed [COEFF_BITS-1:0] DIFFUSE_RESET = 16'sd4096;
	localparam logic [STEP_BITS-1:0]         STEPS_RESET   = 4'd1;

	typedef struct packed {
		logic signed [COEFF_BITS-1:0] advect;
		logic signed [COEFF_BITS-1:0] diffuse;
	} coef_t;

endpackage

>>> src/ads_cell.sv
`timescale 1ns / 1ps

module ads_cell #(
	parameter int SAMPLE_BITS = ads_pkg::DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          enable,
	input  ads_pkg::coef_t                coef,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          out_last
);
	import ads_pkg::*;

	localparam int DA_W  = SAMPLE_BITS + 1;
	localparam int DB_W  = SAMPLE_BITS + 2;
	localparam int PA_W  = DA_W + COEFF_BITS;
	localparam int PB_W  = DB_W + COEFF_BITS;
	localparam int SUM_W = SAMPLE_BITS + 5;
	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	// input skid slot
	logic                          skid_v_q;
	logic signed [SAMPLE_BITS-1:0] skid_x_q;
	logic                          skid_last_q;

	// row state
	logic                          held_q;
	logic                          phase_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] centre_q;

	// pipeline
	logic                          v_s1, v_s2, v_s3;
	logic signed [SAMPLE_BITS-1:0] l_s1, f_s1, r_s1, f_s2, x_s3;
	logic                          last_s1, last_s2, last_s3;
	logic signed [PA_W-1:0]        pa_s2;
	logic signed [PB_W-1:0]        pb_s2;

	logic                          s1_ok, s2_ok, s3_ok;
	logic                          head_valid, head_last, act, emit, take;
	logic signed [SAMPLE_BITS-1:0] head_x, e_l, e_f, e_r;
	logic                          e_last;
	logic signed [DA_W-1:0]        diff_a;
	logic signed [DB_W-1:0]        diff_b;
	logic signed [SUM_W-1:0]       sum;

	assign in_ready   = !skid_v_q;
	assign head_valid = skid_v_q || in_valid;
	assign head_x     = skid_v_q ? skid_x_q : in_sample;
	assign head_last  = skid_v_q ? skid_last_q : in_last;

	assign s3_ok = !v_s3 || out_ready;
	assign s2_ok = !v_s2 || s3_ok;
	assign s1_ok = !v_s1 || s2_ok;
	assign act   = head_valid && s1_ok;

	// Decide what the head beat produces this cycle.
	always_comb begin
		emit   = 1'b0;
		take   = 1'b0;
		e_l    = head_x;
		e_f    = head_x;
		e_r    = head_x;
		e_last = head_last;
		if (act) begin
			if (!enable) begin
				// bypass: a flat neighborhood returns the sample itself
				emit = 1'b1;
				take = 1'b1;
			end else if (phase_q) begin
				// second result at row end, right edge replicated
				emit   = 1'b1;
				take   = 1'b1;
				e_l    = centre_q;
				e_last = 1'b1;
			end else if (!held_q) begin
				// row start: a single-sample row emits at once, else just hold
				emit = head_last;
				take = 1'b1;
			end else begin
				emit   = 1'b1;
				take   = !head_last;
				e_l    = left_q;
				e_f    = centre_q;
				e_last = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
			held_q   <= 1'b0;
			phase_q  <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (take) skid_v_q <= 1'b0;
			end else if (in_valid && !take) begin
				skid_v_q <= 1'b1;
			end
			if (act && enable) begin
				if (phase_q) begin
					held_q  <= 1'b0;
					phase_q <= 1'b0;
				end else if (!held_q) begin
					held_q <= !head_last;
				end else if (head_last) begin
					phase_q <= 1'b1;
				end
			end
			if (s1_ok) v_s1 <= emit;
			if (s2_ok) v_s2 <= v_s1;
			if (s3_ok) v_s3 <= v_s2;
		end
	end

	assign diff_a = DA_W'(r_s1) - DA_W'(l_s1);
	assign diff_b = DB_W'(r_s1) + DB_W'(l_s1) - (DB_W'(f_s1) <<< 1);
	assign sum    = SUM_W'(f_s2) - SUM_W'(pa_s2 >>> FRAC_COEFF)
	              + SUM_W'(pb_s2 >>> FRAC_COEFF);

	always_ff @(posedge clk) begin
		if (!skid_v_q && in_valid && !take) begin
			skid_x_q    <= in_sample;
			skid_last_q <= in_last;
		end
		if (act && enable && !phase_q) begin
			if (!held_q) begin
				left_q   <= head_x;
				centre_q <= head_x;
			end else if (!head_last) begin
				left_q   <= centre_q;
				centre_q <= head_x;
			end
		end
		if (s1_ok && emit) begin
			l_s1    <= e_l;
			f_s1    <= e_f;
			r_s1    <= e_r;
			last_s1 <= e_last;
		end
		if (s2_ok && v_s1) begin
			f_s2    <= f_s1;
			pa_s2   <= PA_W'(diff_a) * PA_W'(coef.advect);
			pb_s2   <= PB_W'(diff_b) * PB_W'(coef.diffuse);
			last_s2 <= last_s1;
		end
		if (s3_ok && v_s2) begin
			if (sum > SAT_HI)      x_s3 <= SAT_HI[SAMPLE_BITS-1:0];
			else if (sum < SAT_LO) x_s3 <= SAT_LO[SAMPLE_BITS-1:0];
			else                   x_s3 <= sum[SAMPLE_BITS-1:0];
			last_s3 <= last_s2;
		end
	end

	assign out_valid  = v_s3;
	assign out_sample = x_s3;
	assign out_last   = last_s3;

	a_phase_parked: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (skid_v_q && held_q))
		else $error("row-end phase without a parked last beat");

	a_phase_closes_row: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q && s1_ok) |=> (!phase_q && !held_q))
		else $error("row state not cleared after final result");

	a_untaken_parks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !take) |=> skid_v_q)
		else $error("accepted beat lost");

endmodule

>>> src/advection_diffusion_stencil.sv
`timescale 1ns / 1ps

// Streaming 1-D advection-diffusion stencil (explicit three-point update).
// Input beats on s_axis carry one grid row in order, tlast on the final
// sample. Output beats on m_axis carry the row after step_count time steps
// (at most MAX_STEPS), tlast on the final result. Each step computes
//   new = f - a*(right - left) + b*(right + left - 2f)
// with row ends replicated; a and b are signed Q2.14, samples signed Q4.20,
// products truncated, results saturated.
// A row of MAX_STEPS cells does the work, one step per cell; cells at or
// beyond step_count pass beats through unchanged (still through their registers).
// Throughput: one beat per cycle while m_axis_tready is high. The last beat
// of a row of two or more samples holds the input while the first enabled
// cell releases its second result; each later cell spends the gap that the
// next row's first sample leaves, unless that next row has a single sample.
// Latency: three register stages per cell, plus one sample of row delay per
// enabled cell (the right neighbor must arrive first).
// Config: cfg_write with cfg_index/cfg_data, only while the block is drained.
// Reset clears all row state and loads a = b = 0.25, step_count = 1.
// When m_axis_tready is low, results hold and the chain fills; s_axis_tready
// drops once the first cell's skid slot is taken.
module advection_diffusion_stencil #(
	parameter int MAX_STEPS   = ads_pkg::DEF_MAX_STEPS,
	parameter int SAMPLE_BITS = ads_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// fields from bit 0: sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
	input  logic                                  s_axis_tlast,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// fields from bit 0: result
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,
	output logic                                  m_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic                                  cfg_write,
	input  logic [ads_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [ads_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import ads_pkg::*;

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	coef_t                 coef_q;
	logic [STEP_BITS-1:0]  step_count_q;

	// Hold the configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.advect  <= ADVECT_RESET;
			coef_q.diffuse <= DIFFUSE_RESET;
			step_count_q   <= STEPS_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_ADVECT:  coef_q.advect  <= $signed(cfg_data[COEFF_BITS-1:0]);
				REG_DIFFUSE: coef_q.diffuse <= $signed(cfg_data[COEFF_BITS-1:0]);
				REG_STEPS:   step_count_q   <= cfg_data[STEP_BITS-1:0];
				default:     ;
			endcase
		end
	end

	// Link k feeds cell k; link MAX_STEPS is the output port.
	logic                          link_valid [MAX_STEPS+1];
	logic                          link_ready [MAX_STEPS+1];
	logic signed [SAMPLE_BITS-1:0] link_x     [MAX_STEPS+1];
	logic                          link_last  [MAX_STEPS+1];

	assign link_valid[0] = s_axis_tvalid;
	assign link_x[0]     = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
	assign link_last[0]  = s_axis_tlast;
	assign s_axis_tready = link_ready[0];

	for (genvar k = 0; k < MAX_STEPS; k++) begin : g_cell
		logic cell_en;
		// Enable the first step_count cells; counts above MAX_STEPS enable all.
		assign cell_en = (32'(k) < 32'(step_count_q));

		ads_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.enable    (cell_en),
			.coef      (coef_q),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_sample (link_x[k]),
			.in_last   (link_last[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_sample(link_x[k+1]),
			.out_last  (link_last[k+1])
		);
	end

	assign m_axis_tvalid          = link_valid[MAX_STEPS];
	assign link_ready[MAX_STEPS]  = m_axis_tready;
	assign m_axis_tdata           = TDATA_W'($unsigned(link_x[MAX_STEPS]));
	assign m_axis_tlast           = link_last[MAX_STEPS];

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Stream test of the advection-diffusion stencil: rows of Q4.20 samples go in
// on s_axis, the cascade model below predicts every output beat, and each
// m_axis beat is matched in order against the oldest prediction.
module tb_top;
	import ads_pkg::*;

	localparam int MAX_STEPS   = DEF_MAX_STEPS;
	localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
	localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;

	// Index with no register behind it; writes there must be ignored.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

	// Three register stages and a skid slot per cell, with ample slack.
	localparam int SETTLE_CYCLES = 16 * MAX_STEPS;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic                   last;
	} row_beat_t;

	// How much of the row window a cell holds.
	typedef enum logic [1:0] {
		FILL_EMPTY,
		FILL_CENTER,
		FILL_PAIR
	} fill_t;

	// Cascade of stencil cells mirrored in software; holds the beats still owed.
	class ftcs_cascade;
		longint      advect;
		longint      diffuse;
		int unsigned steps;
		longint      left_val[MAX_STEPS];
		longint      center_val[MAX_STEPS];
		fill_t       fill[MAX_STEPS];
		row_beat_t   owed_q[$];
		int unsigned errors;

		function new();
			advect  = longint'(ADVECT_RESET);
			diffuse = longint'(DIFFUSE_RESET);
			steps   = 32'(STEPS_RESET);
			errors  = 0;
			for (int k = 0; k < MAX_STEPS; k++) begin
				left_val[k]   = 0;
				center_val[k] = 0;
				fill[k]       = FILL_EMPTY;
			end
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			case (idx)
				REG_ADVECT:  advect  = longint'(signed'(val[COEFF_BITS-1:0]));
				REG_DIFFUSE: diffuse = longint'(signed'(val[COEFF_BITS-1:0]));
				REG_STEPS:   steps   = 32'(val[STEP_BITS-1:0]);
				default: ;
			endcase
		endfunction

		// One explicit step: truncated products, exact sum, saturated.
		function logic [SAMPLE_BITS-1:0] three_point(longint l, longint f, longint r);
			longint v;
			v = f - (((r - l) * advect) >>> FRAC_COEFF)
			      + (((r + l - 2 * f) * diffuse) >>> FRAC_COEFF);
			if (v > SAMPLE_HI)
				v = SAMPLE_HI;
			else if (v < SAMPLE_LO)
				v = SAMPLE_LO;
			return v[SAMPLE_BITS-1:0];
		endfunction

		// Push one accepted input beat through the enabled cells.
		function void take_sample(logic [SAMPLE_BITS-1:0] smp, logic last);
			row_beat_t cur[$];
			row_beat_t nxt[$];
			longint    x;
			int        active;
			cur.push_back(row_beat_t'{smp, last});
			active = (steps > MAX_STEPS) ? MAX_STEPS : steps;
			for (int k = 0; k < active; k++) begin
				nxt.delete();
				foreach (cur[i]) begin
					x = longint'(signed'(cur[i].value));
					if (fill[k] == FILL_EMPTY) begin
						if (cur[i].last) begin
							nxt.push_back(row_beat_t'{three_point(x, x, x), 1'b1});
						end else begin
							left_val[k]   = x;
							center_val[k] = x;
							fill[k]       = FILL_CENTER;
						end
					end else begin
						nxt.push_back(row_beat_t'{three_point(left_val[k], center_val[k], x),
							1'b0});
						if (cur[i].last) begin
							nxt.push_back(row_beat_t'{three_point(center_val[k], x, x), 1'b1});
							left_val[k]   = 0;
							center_val[k] = 0;
							fill[k]       = FILL_EMPTY;
						end else begin
							left_val[k]   = center_val[k];
							center_val[k] = x;
							fill[k]       = FILL_PAIR;
						end
					end
				end
				cur = nxt;
			end
			foreach (cur[i])
				owed_q.push_back(cur[i]);
		endfunction

		task match_result(logic [SAMPLE_BITS-1:0] got, logic got_last);
			row_beat_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("result %h (last %b) with nothing owed", got, got_last));
			end else begin
				want = owed_q.pop_front();
				if (got !== want.value)
					report($sformatf("result %h, predicted %h", got, want.value));
				if (got_last !== want.last)
					report($sformatf("last flag %b, predicted %b", got_last, want.last));
			end
		endtask
	endclass

	logic                      clk;
	logic                      arst_n        = 1'b0;
	logic [DATA_W-1:0]         s_axis_tdata  = '0;
	logic                      s_axis_tlast  = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [DATA_W-1:0]         m_axis_tdata;
	logic                      m_axis_tlast;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic                      cfg_write     = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;

	ftcs_cascade cascade;
	int          src_idle  = 0;
	int          sink_idle = 0;
	bit          hold_req  = 1'b0;
	int          hold_count;
	int          cycle_count;

	advection_diffusion_stencil #(
		.MAX_STEPS   (MAX_STEPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one beat, idling first at the sender's rate; return at the
	// edge that accepts it and log it into the cascade model.
	task automatic send_beat(input logic [SAMPLE_BITS-1:0] smp, input logic last);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= DATA_W'(smp);
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		cascade.take_sample(smp, last);
	endtask

	// Write one register, then drop the enable again before returning.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cascade.set_reg(idx, val);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Drop tvalid, wait for every owed beat, then let the cells settle so a
	// beat that yields no result cannot be in flight at a register write.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (cascade.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly full-range noise, with extremes and small values mixed in.
	function automatic logic [SAMPLE_BITS-1:0] next_sample();
		case ($urandom_range(9))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2, 3:    return SAMPLE_BITS'(int'($urandom_range(131071)) - 65536);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Rows of random length; the final row is cut short when the budget runs
	// out, so the next setting starts with cells holding a partial row.
	task automatic send_rows(input int budget);
		int row_len;
		int sent;
		sent = 0;
		while (sent < budget) begin
			row_len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
			for (int j = 0; j < row_len && sent < budget; j++) begin
				send_beat(next_sample(), j == row_len - 1);
				sent++;
			end
		end
	endtask

	task automatic random_config();
		logic [CFG_DATA_BITS-1:0] a;
		logic [CFG_DATA_BITS-1:0] b;
		logic [CFG_DATA_BITS-1:0] st;
		// Keep coefficients moderate half the time so results do not all clip.
		a = $urandom_range(1) ? CFG_DATA_BITS'($urandom)
			: CFG_DATA_BITS'($urandom_range(16383)) - CFG_DATA_BITS'(8192);
		b = $urandom_range(1) ? CFG_DATA_BITS'($urandom)
			: CFG_DATA_BITS'($urandom_range(16383)) - CFG_DATA_BITS'(8192);
		st = CFG_DATA_BITS'($urandom);
		st[STEP_BITS-1:0] = STEP_BITS'(($urandom_range(3) == 0) ? $urandom_range(15)
			: $urandom_range(1, 8));
		write_reg(REG_ADVECT, a);
		write_reg(REG_DIFFUSE, b);
		write_reg(REG_STEPS, st);
	endtask

	// Sink: random tready at the current idle rate; on request, hold off for
	// a long stretch so the chain fills and s_axis_tready drops.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				hold_req = 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle);
			end
		end
	end

	// Check each accepted output beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			cascade.match_result(m_axis_tdata[SAMPLE_BITS-1:0], m_axis_tlast);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		int waited;
		cascade = new();
		src_idle  = 23;
		sink_idle = 75;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients and one step: single-sample rows at both extremes,
		// then a row that alternates between the two extremes.
		send_beat(SAMPLE_MAX, 1'b1);
		send_beat(SAMPLE_MIN, 1'b1);
		send_beat(SAMPLE_MAX, 1'b0);
		send_beat(SAMPLE_MIN, 1'b0);
		send_beat(SAMPLE_MAX, 1'b0);
		send_beat(SAMPLE_MIN, 1'b1);
		quiesce();

		// Coefficient extremes with the full cascade.
		write_reg(REG_ADVECT, 16'h7FFF);
		write_reg(REG_DIFFUSE, 16'h8000);
		write_reg(REG_STEPS, CFG_DATA_BITS'(MAX_STEPS));
		for (int j = 0; j < 5; j++)
			send_beat((j % 2) ? SAMPLE_MIN : SAMPLE_MAX, j == 4);
		quiesce();

		// Opposite extremes, step count past the cascade depth, and a write
		// to the unused index.
		write_reg(REG_ADVECT, 16'h8000);
		write_reg(REG_DIFFUSE, 16'h7FFF);
		write_reg(REG_STEPS, 16'h000F);
		write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
		for (int j = 0; j < 4; j++)
			send_beat(SAMPLE_BITS'($urandom), j == 3);
		quiesce();

		// Zero steps: beats pass straight through with their own last flags.
		write_reg(REG_STEPS, 16'h0000);
		send_beat(SAMPLE_BITS'($urandom), 1'b0);
		send_beat(SAMPLE_BITS'($urandom), 1'b1);
		send_beat(SAMPLE_BITS'($urandom), 1'b0);
		quiesce();

		// Step count raised in the middle of a row.
		write_reg(REG_STEPS, 16'h0002);
		send_beat(SAMPLE_BITS'($urandom), 1'b0);
		send_beat(SAMPLE_BITS'($urandom), 1'b0);
		quiesce();
		write_reg(REG_STEPS, 16'h0004);
		send_beat(SAMPLE_BITS'($urandom), 1'b0);
		send_beat(SAMPLE_BITS'($urandom), 1'b1);
		quiesce();

		// Random rows: slow sink, then slow source, then full rate with one
		// long sink hold-off.
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					src_idle  = 23;
					sink_idle = 75;
				end
				1: begin
					src_idle  = 75;
					sink_idle = 23;
				end
				default: begin
					src_idle  = 0;
					sink_idle = 0;
					hold_req  = 1'b1;
				end
			endcase
			for (int q = 0; q < 2; q++) begin
				random_config();
				send_rows(51);
				quiesce();
			end
		end

		// Drain: give any stray beat time to show up before the verdict.
		waited = 0;
		while (cascade.owed_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (cascade.owed_q.size() != 0)
			cascade.report($sformatf("%0d predicted results never arrived",
				cascade.owed_q.size()));

		if (cascade.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
src/ads_pkg.sv
src/ads_cell.sv
src/advection_diffusion_stencil.sv
tb/tb_top.sv
